[design/lvva_pkg.sv]
package lvva_pkg;

   localparam int DIST_W     = 24;
   localparam int TIME_W     = 48;
   localparam int EGO_W      = 18;
   localparam int OUT_W      = 24;
   localparam int LIMIT_W    = 18;
   localparam int CAP_W      = 19;
   localparam int WLEN_W     = 5;
   localparam int CSR_DATA_W = 19;
   localparam int CSR_IDX_W  = 2;

   localparam int DIFF_W  = DIST_W + 1;
   localparam int SCALE_W = 20;
   localparam logic [SCALE_W-1:0] SPEED_SCALE = 20'd1000000;
   localparam int NUM_W   = DIFF_W + SCALE_W;
   localparam int DEN_W   = TIME_W;
   localparam int SPD_W   = 20;
   localparam int STEP_W  = $clog2(NUM_W + 1);
   localparam int WIN_CALC_W = 8;

   localparam int DEFAULT_MAX_WINDOW = 16;

   localparam logic [LIMIT_W-1:0]      LIMIT_RESET = 18'd10000;
   localparam logic signed [CAP_W-1:0] CAP_RESET   = 19'sd50000;
   localparam logic [WLEN_W-1:0]       WLEN_RESET  = 5'd10;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_REL_LIMIT  = 2'd0,
      CSR_SPEED_CAP  = 2'd1,
      CSR_WINDOW_LEN = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      RSP_NONE,
      RSP_REJECT,
      RSP_SPEED
   } rsp_kind_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CLASSIFY,
      ST_DIFF,
      ST_ABS,
      ST_SCALE,
      ST_DIV_SPEED,
      ST_WAIT_SPEED,
      ST_SPEED,
      ST_COMMIT,
      ST_DIV_MEAN,
      ST_WAIT_MEAN,
      ST_EMIT
   } ctrl_state_type;

   typedef struct packed {
      logic         capture;
      logic         diff;
      logic         absval;
      logic         scale;
      logic         div_start;
      logic         div_mean;
      logic         speed;
      logic         commit;
      logic         load_rsp;
      rsp_kind_type rsp_kind;
   } ctrl_cmd_type;

   typedef struct packed {
      logic present;
      logic hist_empty;
      logic dt_zero;
      logic div_busy;
      logic over_limit;
   } dp_status_type;

endpackage

[design/lvva_req_if.sv]
interface lvva_req_if import lvva_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic                     vehicle_present;
   logic signed [DIST_W-1:0] nearest_distance;
   logic [TIME_W-1:0]        frame_time;
   logic signed [EGO_W-1:0]  ego_speed;

   modport source (
      output valid, vehicle_present, nearest_distance, frame_time, ego_speed,
      input  ready
   );

   modport sink (
      input  valid, vehicle_present, nearest_distance, frame_time, ego_speed,
      output ready
   );
endinterface

[design/lvva_rsp_if.sv]
interface lvva_rsp_if import lvva_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic                    speed_valid;
   logic                    frame_rejected;
   logic signed [OUT_W-1:0] averaged_speed;

   modport source (
      output valid, speed_valid, frame_rejected, averaged_speed,
      input  ready
   );

   modport sink (
      input  valid, speed_valid, frame_rejected, averaged_speed,
      output ready
   );
endinterface

[design/lvva_divider.sv]
module lvva_divider import lvva_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [NUM_W-1:0]  dividend,
   input  logic [DEN_W-1:0]  divisor,
   input  logic [STEP_W-1:0] steps,
   output logic              busy,
   output logic [NUM_W-1:0]  quotient,
   output logic [DEN_W-1:0]  remainder
);

   logic              busy_ff;
   logic [NUM_W-1:0]  dvd_ff;
   logic [NUM_W-1:0]  quo_ff;
   logic [DEN_W-1:0]  rem_ff;
   logic [DEN_W-1:0]  dvs_ff;
   logic [STEP_W-1:0] cnt_ff;

   logic [DEN_W:0]    trial;
   logic [DEN_W:0]    trial_diff;
   logic              fits;
   logic [DEN_W-1:0]  rem_in;
   logic [NUM_W-1:0]  quo_in;
   logic [NUM_W-1:0]  dvd_in;

   // One restoring step per cycle, dividend bits taken from the top.
   always_comb begin
      trial      = {rem_ff, dvd_ff[NUM_W-1]};
      trial_diff = trial - {1'b0, dvs_ff};
      fits       = (trial >= {1'b0, dvs_ff});
      rem_in     = fits ? trial_diff[DEN_W-1:0] : trial[DEN_W-1:0];
      quo_in     = {quo_ff[NUM_W-2:0], fits};
      dvd_in     = {dvd_ff[NUM_W-2:0], 1'b0};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else if (start) begin
         busy_ff <= 1'b1;
      end else if (busy_ff && cnt_ff == STEP_W'(1)) begin
         busy_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         dvd_ff <= dividend;
         dvs_ff <= divisor;
         rem_ff <= '0;
         quo_ff <= '0;
         cnt_ff <= steps;
      end else if (busy_ff) begin
         dvd_ff <= dvd_in;
         rem_ff <= rem_in;
         quo_ff <= quo_in;
         cnt_ff <= cnt_ff - 1'b1;
      end
   end

   assign busy      = busy_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff)
      else $error("divider started while busy");

   a_step_count: assert property (@(posedge clock) disable iff (reset)
      $fell(busy_ff) |-> $past(cnt_ff) == STEP_W'(1))
      else $error("divider finished before its last step");

endmodule

[design/lvva_datapath.sv]
module lvva_datapath import lvva_pkg::*; #(
   parameter int MAX_WINDOW = DEFAULT_MAX_WINDOW
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_write_enable,
   input  logic [CSR_IDX_W-1:0]     csr_index,
   input  logic [CSR_DATA_W-1:0]    csr_write_data,
   input  logic                     vehicle_present,
   input  logic signed [DIST_W-1:0] nearest_distance,
   input  logic [TIME_W-1:0]        frame_time,
   input  logic signed [EGO_W-1:0]  ego_speed,
   input  ctrl_cmd_type             cmd,
   output dp_status_type            status,
   output logic                     speed_valid,
   output logic                     frame_rejected,
   output logic signed [OUT_W-1:0]  averaged_speed
);

   localparam int IDX_W  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
   localparam int CNT_W  = $clog2(MAX_WINDOW + 1);
   localparam int SUM_W  = SPD_W + CNT_W;
   localparam int SLOT_W = CNT_W + 1;

   logic [LIMIT_W-1:0]        limit_ff;
   logic signed [CAP_W-1:0]   cap_ff;
   logic [WLEN_W-1:0]         wlen_ff;

   logic                      present_ff;
   logic signed [DIST_W-1:0]  dist_ff;
   logic [TIME_W-1:0]         now_ff;
   logic signed [EGO_W-1:0]   ego_ff;
   logic signed [DIST_W-1:0]  last_dist_ff;
   logic [TIME_W-1:0]         last_time_ff;

   logic signed [DIFF_W-1:0]  dd_ff;
   logic signed [DIFF_W-1:0]  dd_in;
   logic [TIME_W-1:0]         dt_ff;
   logic [TIME_W-1:0]         dt_in;
   logic [DIFF_W-1:0]         abs_dd_ff;
   logic [DIFF_W-1:0]         abs_dd_in;
   logic [DEN_W-1:0]          den_ff;
   logic [DEN_W-1:0]          den_in;
   logic                      neg_ff;
   logic                      neg_in;
   logic [NUM_W-1:0]          num_ff;
   logic [NUM_W-1:0]          num_in;

   logic signed [SPD_W-1:0]   spd_ff;
   logic signed [SPD_W-1:0]   spd_in;
   logic signed [SPD_W-1:0]   rel_mag;
   logic signed [SPD_W-1:0]   rel;
   logic signed [SPD_W-1:0]   spd_sum;
   logic signed [SPD_W-1:0]   cap_ext;

   logic signed [SUM_W-1:0]   sum_ff;
   logic signed [SUM_W-1:0]   sum_in;
   logic [CNT_W-1:0]          count_ff;
   logic [CNT_W-1:0]          count_in;
   logic [IDX_W-1:0]          head_ff;
   logic [IDX_W-1:0]          head_in;

   logic signed [SPD_W-1:0]   hist_mem [MAX_WINDOW];
   logic signed [SPD_W-1:0]   rd_ff;

   logic [WIN_CALC_W-1:0]     win_wide;
   logic [CNT_W-1:0]          win;
   logic                      drop;
   logic signed [SUM_W-1:0]   old_ext;
   logic signed [SUM_W-1:0]   new_ext;
   logic signed [SUM_W-1:0]   drop_val;
   logic [CNT_W-1:0]          count_after;
   logic [SLOT_W-1:0]         slot_sum;
   logic [SLOT_W-1:0]         slot_wrap;
   logic [IDX_W-1:0]          slot_idx;

   logic [SUM_W-1:0]          abs_sum;
   logic [NUM_W-1:0]          div_dividend;
   logic [DEN_W-1:0]          div_divisor;
   logic [STEP_W-1:0]         div_steps;
   logic                      div_busy;
   logic [NUM_W-1:0]          div_quo;
   logic [DEN_W-1:0]          div_rem;
   logic                      over_limit;
   logic signed [OUT_W-1:0]   mean_mag;
   logic signed [OUT_W-1:0]   mean;

   logic                      speed_valid_ff;
   logic                      frame_rejected_ff;
   logic signed [OUT_W-1:0]   averaged_speed_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_RESET;
         cap_ff   <= CAP_RESET;
         wlen_ff  <= WLEN_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_REL_LIMIT:  limit_ff <= csr_write_data[LIMIT_W-1:0];
            CSR_SPEED_CAP:  cap_ff   <= $signed(csr_write_data[CAP_W-1:0]);
            CSR_WINDOW_LEN: wlen_ff  <= csr_write_data[WLEN_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      dd_in     = DIFF_W'(dist_ff) - DIFF_W'(last_dist_ff);
      dt_in     = now_ff - last_time_ff;
      abs_dd_in = dd_ff[DIFF_W-1] ? DIFF_W'(-dd_ff) : DIFF_W'(dd_ff);
      den_in    = dt_ff[TIME_W-1] ? -dt_ff : dt_ff;
      neg_in    = dd_ff[DIFF_W-1] ^ dt_ff[TIME_W-1];
      num_in    = NUM_W'(abs_dd_ff) * NUM_W'(SPEED_SCALE);
   end

   // The limit test uses the exact quotient: a nonzero remainder at the
   // limit already exceeds it.
   always_comb begin
      over_limit = (div_quo > NUM_W'(limit_ff)) ||
                   ((div_quo == NUM_W'(limit_ff)) && (div_rem != '0));
      rel_mag    = SPD_W'(div_quo[LIMIT_W-1:0]);
      if (count_ff == '0) begin
         rel = '0;
      end else begin
         rel = neg_ff ? -rel_mag : rel_mag;
      end
      spd_sum = rel + SPD_W'(ego_ff);
      cap_ext = SPD_W'(cap_ff);
      spd_in  = (spd_sum > cap_ext) ? cap_ext : spd_sum;
   end

   always_comb begin
      if (wlen_ff == '0) begin
         win_wide = WIN_CALC_W'(1);
      end else if (WIN_CALC_W'(wlen_ff) > WIN_CALC_W'(MAX_WINDOW)) begin
         win_wide = WIN_CALC_W'(MAX_WINDOW);
      end else begin
         win_wide = WIN_CALC_W'(wlen_ff);
      end
      win  = win_wide[CNT_W-1:0];
      drop = (count_ff >= win);

      old_ext  = SUM_W'(rd_ff);
      new_ext  = SUM_W'(spd_ff);
      drop_val = drop ? old_ext : '0;
      sum_in   = sum_ff - drop_val + new_ext;

      if (!drop) begin
         head_in = head_ff;
      end else if (head_ff == IDX_W'(MAX_WINDOW - 1)) begin
         head_in = '0;
      end else begin
         head_in = head_ff + 1'b1;
      end
      count_after = drop ? count_ff - 1'b1 : count_ff;
      count_in    = count_after + 1'b1;

      slot_sum  = SLOT_W'(head_in) + SLOT_W'(count_after);
      slot_wrap = (slot_sum >= SLOT_W'(MAX_WINDOW)) ? slot_sum - SLOT_W'(MAX_WINDOW)
                                                     : slot_sum;
      slot_idx  = slot_wrap[IDX_W-1:0];
   end

   always_comb begin
      abs_sum      = sum_ff[SUM_W-1] ? SUM_W'(-sum_ff) : SUM_W'(sum_ff);
      div_dividend = cmd.div_mean ? (NUM_W'(abs_sum) << (NUM_W - SUM_W)) : num_ff;
      div_divisor  = cmd.div_mean ? DEN_W'(count_ff) : den_ff;
      div_steps    = cmd.div_mean ? STEP_W'(SUM_W) : STEP_W'(NUM_W);
      mean_mag     = OUT_W'(div_quo[SPD_W-1:0]);
      mean         = sum_ff[SUM_W-1] ? -mean_mag : mean_mag;
   end

   lvva_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .steps     (div_steps),
      .busy      (div_busy),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         present_ff <= vehicle_present;
         dist_ff    <= nearest_distance;
         now_ff     <= frame_time;
         ego_ff     <= ego_speed;
      end
      if (cmd.diff) begin
         dd_ff <= dd_in;
         dt_ff <= dt_in;
      end
      if (cmd.absval) begin
         abs_dd_ff <= abs_dd_in;
         den_ff    <= den_in;
         neg_ff    <= neg_in;
      end
      if (cmd.scale) begin
         num_ff <= num_in;
      end
      if (cmd.speed) begin
         spd_ff <= spd_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_dist_ff <= '0;
         last_time_ff <= '0;
         sum_ff       <= '0;
         count_ff     <= '0;
         head_ff      <= '0;
      end else if (cmd.commit) begin
         last_dist_ff <= dist_ff;
         last_time_ff <= now_ff;
         sum_ff       <= sum_in;
         count_ff     <= count_in;
         head_ff      <= head_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         hist_mem[slot_idx] <= spd_ff;
      end
      rd_ff <= hist_mem[head_ff];
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         speed_valid_ff    <= (cmd.rsp_kind == RSP_SPEED);
         frame_rejected_ff <= (cmd.rsp_kind == RSP_REJECT);
         averaged_speed_ff <= (cmd.rsp_kind == RSP_SPEED) ? mean : '0;
      end
   end

   assign status.present    = present_ff;
   assign status.hist_empty = (count_ff == '0);
   assign status.dt_zero    = (dt_ff == '0);
   assign status.div_busy   = div_busy;
   assign status.over_limit = over_limit;

   assign speed_valid    = speed_valid_ff;
   assign frame_rejected = frame_rejected_ff;
   assign averaged_speed = averaged_speed_ff;

   a_commit_fills: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> count_ff != '0)
      else $error("history empty after an accepted speed");

   a_window_bounds: assert property (@(posedge clock) disable iff (reset)
      head_ff <= IDX_W'(MAX_WINDOW - 1) && count_ff <= CNT_W'(MAX_WINDOW))
      else $error("history pointer or count out of range");

endmodule

[design/lvva_ctrl.sv]
module lvva_ctrl import lvva_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  logic          rsp_ready,
   input  dp_status_type status,
   output logic          req_ready,
   output logic          rsp_valid,
   output ctrl_cmd_type  cmd
);

   ctrl_state_type state_ff;
   ctrl_state_type state_in;
   rsp_kind_type   kind_ff;
   rsp_kind_type   kind_in;
   logic           rsp_valid_ff;
   logic           rsp_valid_in;
   logic           slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      kind_in  = kind_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_CLASSIFY;
            end
         end
         ST_CLASSIFY: begin
            if (!status.present) begin
               kind_in  = RSP_NONE;
               state_in = ST_EMIT;
            end else if (status.hist_empty) begin
               state_in = ST_SPEED;
            end else begin
               state_in = ST_DIFF;
            end
         end
         ST_DIFF: begin
            state_in = ST_ABS;
         end
         ST_ABS: begin
            state_in = ST_SCALE;
         end
         ST_SCALE: begin
            if (status.dt_zero) begin
               kind_in  = RSP_REJECT;
               state_in = ST_EMIT;
            end else begin
               state_in = ST_DIV_SPEED;
            end
         end
         ST_DIV_SPEED: begin
            state_in = ST_WAIT_SPEED;
         end
         ST_WAIT_SPEED: begin
            if (!status.div_busy) begin
               if (status.over_limit) begin
                  kind_in  = RSP_REJECT;
                  state_in = ST_EMIT;
               end else begin
                  state_in = ST_SPEED;
               end
            end
         end
         ST_SPEED: begin
            state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            state_in = ST_DIV_MEAN;
         end
         ST_DIV_MEAN: begin
            state_in = ST_WAIT_MEAN;
         end
         ST_WAIT_MEAN: begin
            if (!status.div_busy) begin
               kind_in  = RSP_SPEED;
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd          = '0;
      cmd.rsp_kind = kind_ff;
      req_ready    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         ST_DIFF:      cmd.diff   = 1'b1;
         ST_ABS:       cmd.absval = 1'b1;
         ST_SCALE:     cmd.scale  = 1'b1;
         ST_DIV_SPEED: cmd.div_start = 1'b1;
         ST_SPEED:     cmd.speed  = 1'b1;
         ST_COMMIT:    cmd.commit = 1'b1;
         ST_DIV_MEAN: begin
            cmd.div_start = 1'b1;
            cmd.div_mean  = 1'b1;
         end
         ST_EMIT:      cmd.load_rsp = slot_free;
         default: begin
         end
      endcase
   end

   assign rsp_valid_in = cmd.load_rsp || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         kind_ff      <= RSP_NONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         kind_ff      <= kind_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_rsp_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_EMIT))
      else $error("result item raised outside the emit state");

   a_emit_waits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && rsp_valid_ff && !rsp_ready) |=> state_ff == ST_EMIT)
      else $error("result overwritten while the receiver stalls");

endmodule

[design/lead_vehicle_velocity_averager_unit.sv]
// Lead vehicle speed averager.
// The req_bus channel takes one item per sensor frame: the lead vehicle flag,
// the nearest forward distance, the frame time and the ego speed. The rsp_bus
// channel returns exactly one item for each accepted item: an averaged speed,
// a rejected frame, or an empty result when no vehicle is present.
// Both channels move an item when valid and ready are high at a clock edge.
// The user must write the speed limit, the speed cap and the window length on
// the csr port only while the block is idle; the block itself does not enforce this.
// One item is processed at a time. A frame without a vehicle goes straight to
// its result; a frame with a zero elapsed time is rejected after the distance
// and time differences; the first frame into an empty history skips the
// differences and the speed division; a frame over the speed limit is rejected
// after the speed division; an accepted frame runs the speed division and then
// the mean division. The serial divider gives one quotient bit per cycle and
// does both divisions. The time an item takes does not depend on the window
// length. The next item is taken in the cycle after a result is stored.
// The finished result sits in an output register, so the next item is taken
// while the receiver stalls; that item then waits before its result is
// stored until the register is free.
// Synchronous reset restores the register defaults and empties the history.
module lead_vehicle_velocity_averager_unit import lvva_pkg::*; #(
   parameter int MAX_WINDOW = DEFAULT_MAX_WINDOW
) (
   input  logic                  clock,
   input  logic                  reset,
   lvva_req_if.sink              req_bus,
   lvva_rsp_if.source            rsp_bus,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data
);

   ctrl_cmd_type  cmd;
   dp_status_type status;

   lvva_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .status    (status),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .cmd       (cmd)
   );

   lvva_datapath #(
      .MAX_WINDOW (MAX_WINDOW)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .vehicle_present  (req_bus.vehicle_present),
      .nearest_distance (req_bus.nearest_distance),
      .frame_time       (req_bus.frame_time),
      .ego_speed        (req_bus.ego_speed),
      .cmd              (cmd),
      .status           (status),
      .speed_valid      (rsp_bus.speed_valid),
      .frame_rejected   (rsp_bus.frame_rejected),
      .averaged_speed   (rsp_bus.averaged_speed)
   );

endmodule
